[sv/load_balance_target_select_macros.svh]
// Assertion macros for the load balance target select datapath.
`ifndef LOAD_BALANCE_TARGET_SELECT_MACROS_SVH
`define LOAD_BALANCE_TARGET_SELECT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define LBTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LBTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/lbts_pkg.sv]
// Shared constants and controller/datapath interface types for the target selector.
package lbts_pkg;

    // Field widths of the item formats and the default processor count.
    localparam int LOAD_W       = 15;
    localparam int CNT_W        = 8;
    localparam int IDX_IN_W     = 3;
    localparam int TDATA_W      = 16;
    localparam int DEF_NUM_CPUS = 8;

    // Load units per ready task are 128, so a task count is a load shifted down by 7.
    localparam int TASK_SHIFT = 7;
    // Smallest load spread at which a single task still moves on a small gap, 128*2-1.
    localparam logic [LOAD_W-1:0] MIN_SPAN = LOAD_W'(255);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_own;
        logic upd_wr;
        logic own_cap;
        logic scan_rd;
        logic div_start;
        logic decide;
        logic zero_resp;
    } lbts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic me_ok;
        logic scan_last;
        logic div_busy;
        logic out_free;
    } lbts_sts_t;

endpackage

[sv/load_balance_target_select.sv]
// Top level of the load balance target selector: controller plus datapath.
//
// Use: one stream in, one stream out. An input item carries s_tuser = 0 for a
// load update or 1 for a balance query, with the processor index and ready
// count in s_tdata. An update blends the count into that processor's load
// average and gives no result. A query gives one result item: m_tuser is the
// migrate flag, m_tdata carries the target processor and the task count.
// An update reads and rewrites its own table entry before the next item can be
// taken. A query reads the load table one entry per cycle through its single read
// port, and the average comes from a registered reciprocal multiplication. Items
// are handled one at a time, so a new item is not taken until the last is done.
// Reset makes all load averages read as zero and empties the result register.
// The result is held in an output register; while m_tready is low the block
// still takes and works on the next item, and only stalls when a new result
// is ready while the previous one has not been taken.
module load_balance_target_select #(
    parameter int NUM_CPUS = lbts_pkg::DEF_NUM_CPUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cpu_index [2:0], ready_count [10:3], zero pad [15:11]
    input  logic [lbts_pkg::TDATA_W-1:0]  s_tdata,
    // command [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // target_index [2:0], task_count [10:3], zero pad [15:11]
    output logic [lbts_pkg::TDATA_W-1:0]  m_tdata,
    // migrate [0]
    output logic                          m_tuser
);

    lbts_pkg::lbts_cmd_t cmd;
    lbts_pkg::lbts_sts_t sts;

    // Sequencer.
    lbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, accumulators, divider and result register.
    lbts_dp #(
        .NUM_CPUS (NUM_CPUS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

[sv/lbts_div.sv]
// Average unit that divides the load total by the processor count through a reciprocal product.
module lbts_div #(
    parameter int NUM_CPUS = lbts_pkg::DEF_NUM_CPUS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic [lbts_pkg::LOAD_W+$clog2(NUM_CPUS)-1:0]    dividend,
    output logic [lbts_pkg::LOAD_W-1:0]                     quotient,
    output logic                                            busy
);

    localparam int LOAD_W  = lbts_pkg::LOAD_W;
    localparam int REM_W   = $clog2(NUM_CPUS);
    localparam int SUM_W   = LOAD_W + REM_W;
    localparam int SHIFT   = SUM_W + REM_W;
    localparam int RCP_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RCP_W;
    // Rounded-up reciprocal; exact for every total below 2^SUM_W.
    localparam longint unsigned RCP_FULL =
        ((64'd1 << SHIFT) + 64'(NUM_CPUS) - 64'd1) / 64'(NUM_CPUS);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    logic [SUM_W-1:0]  dvd_reg;
    logic [LOAD_W-1:0] quo_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] product;

    // Total times the reciprocal; the quotient sits above the scaling shift.
    assign product = {{RCP_W{1'b0}}, dvd_reg} * {{SUM_W{1'b0}}, RCP};

    // Step control: the total is captured first, and the product is registered in the cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Operand and quotient registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            quo_reg <= product[SHIFT+LOAD_W-1:SHIFT];
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

[sv/lbts_ctrl.sv]
// Controller state machine that sequences updates, table scans and decisions.
module lbts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lbts_pkg::lbts_sts_t sts,
    output lbts_pkg::lbts_cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        UPD_RD,
        UPD_WR,
        Q_OWN,
        Q_CAP,
        Q_SCAN,
        Q_DRAIN,
        Q_DIV0,
        Q_DIV,
        Q_DECIDE,
        Q_ZERO
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = DISPATCH;
                end
            end
            DISPATCH:
            begin
                if (!sts.is_query)
                begin
                    state_next = sts.me_ok ? UPD_RD : IDLE;
                end
                else
                begin
                    state_next = sts.me_ok ? Q_OWN : Q_ZERO;
                end
            end
            UPD_RD:   state_next = UPD_WR;
            UPD_WR:   state_next = IDLE;
            Q_OWN:    state_next = Q_CAP;
            Q_CAP:    state_next = Q_SCAN;
            Q_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = Q_DRAIN;
                end
            end
            Q_DRAIN:  state_next = Q_DIV0;
            Q_DIV0:   state_next = Q_DIV;
            Q_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = Q_DECIDE;
                end
            end
            Q_DECIDE, Q_ZERO:
            begin
                if (sts.out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:  state_next = IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == IDLE) && s_tvalid;
        cmd.rd_own    = (state_reg == UPD_RD) || (state_reg == Q_OWN);
        cmd.upd_wr    = (state_reg == UPD_WR);
        cmd.own_cap   = (state_reg == Q_CAP);
        cmd.scan_rd   = (state_reg == Q_SCAN);
        cmd.div_start = (state_reg == Q_DIV0);
        cmd.decide    = (state_reg == Q_DECIDE) && sts.out_free;
        cmd.zero_resp = (state_reg == Q_ZERO) && sts.out_free;
    end

    assign s_tready = (state_reg == IDLE);

endmodule

[sv/lbts_dp.sv]
// Datapath: load table memory, scan accumulators, average divider and result register.
`include "load_balance_target_select_macros.svh"

module lbts_dp #(
    parameter int NUM_CPUS = lbts_pkg::DEF_NUM_CPUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lbts_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [lbts_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  lbts_pkg::lbts_cmd_t           cmd,
    output lbts_pkg::lbts_sts_t           sts
);

    localparam int LOAD_W = lbts_pkg::LOAD_W;
    localparam int CNT_W  = lbts_pkg::CNT_W;
    localparam int IN_W   = lbts_pkg::IDX_IN_W;
    localparam int IDX_W  = $clog2(NUM_CPUS);
    localparam int SUM_W  = LOAD_W + IDX_W;
    localparam int CMP_W  = IDX_W + IN_W + 1;
    localparam int PAD_W  = lbts_pkg::TDATA_W - IN_W - CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CPUS - 1);

    // Latched input item.
    logic              query_reg;
    logic [IN_W-1:0]   me_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  me_a;

    // Load table and per-entry valid bits.
    logic [LOAD_W-1:0] mem [NUM_CPUS];
    logic [NUM_CPUS-1:0] valid_reg;
    logic [LOAD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [LOAD_W-1:0] rd_load;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [LOAD_W:0]   blend_sum;
    logic [LOAD_W-1:0] wr_data;

    // Scan state.
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_d_reg;
    logic              acc_pend_reg;
    logic [LOAD_W-1:0] this_reg;
    logic [LOAD_W-1:0] min_reg;
    logic [IDX_W-1:0]  best_reg;
    logic              found_reg;
    logic [SUM_W-1:0]  total_reg;

    // Average and decision.
    logic [LOAD_W-1:0] ave;
    logic              div_busy;
    logic [LOAD_W+1:0] this_x4;
    logic [LOAD_W+2:0] min_x5;
    logic              no_mig;
    logic [LOAD_W-1:0] d_low;
    logic [LOAD_W-1:0] d_high;
    logic [LOAD_W-1:0] gap;
    logic [LOAD_W-1:0] span;
    logic              mig;
    logic [CNT_W-1:0]  mig_cnt;

    // Result register.
    logic              out_valid_reg;
    logic              out_mig_reg;
    logic [IN_W-1:0]   out_tgt_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_load;
    logic              out_free;

    // Input latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            query_reg <= s_tuser;
            me_reg    <= s_tdata[IN_W-1:0];
            cnt_reg   <= s_tdata[IN_W+CNT_W-1:IN_W];
        end
    end

    assign me_a = IDX_W'(me_reg);

    // Table port: the own entry for updates and queries, the scan index otherwise.
    assign rd_en   = cmd.rd_own | cmd.scan_rd;
    assign rd_addr = cmd.rd_own ? me_a : idx_reg;
    assign rd_load = rd_vld_reg ? rd_data_reg : '0;

    // Blend of the old average with the new ready count, halved.
    assign blend_sum = {1'b0, rd_load} + {1'b0, cnt_reg, {lbts_pkg::TASK_SHIFT{1'b0}}};
    assign wr_data   = blend_sum[LOAD_W:1];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.upd_wr)
        begin
            mem[me_a] <= wr_data;
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            acc_pend_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.scan_rd;
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (cmd.upd_wr)
            begin
                valid_reg[me_a] <= 1'b1;
            end
        end
    end

    // Scan: running total and the lowest load among the other processors.
    always_ff @(posedge clk)
    begin
        idx_d_reg <= idx_reg;
        if (cmd.own_cap)
        begin
            idx_reg   <= '0;
            this_reg  <= rd_load;
            min_reg   <= rd_load;
            best_reg  <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.scan_rd)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (acc_pend_reg)
            begin
                total_reg <= total_reg + SUM_W'(rd_load);
                if ((idx_d_reg != me_a) && (rd_load <= min_reg))
                begin
                    min_reg   <= rd_load;
                    best_reg  <= idx_d_reg;
                    found_reg <= 1'b1;
                end
            end
        end
    end

    lbts_div #(
        .NUM_CPUS (NUM_CPUS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .quotient (ave),
        .busy     (div_busy)
    );

    // Migration decision: 100*this < 125*min is the same test as 4*this < 5*min.
    always_comb
    begin
        this_x4 = {this_reg, 2'b00};
        min_x5  = {1'b0, min_reg, 2'b00} + {3'b000, min_reg};
        no_mig  = !found_reg || (this_reg <= min_reg) || (this_reg <= ave)
                  || ({1'b0, this_x4} < min_x5);
        d_low   = ave - min_reg;
        d_high  = this_reg - ave;
        gap     = (d_low < d_high) ? d_low : d_high;
        span    = this_reg - min_reg;
        if (no_mig)
        begin
            mig     = 1'b0;
            mig_cnt = '0;
        end
        else if (gap[LOAD_W-1:lbts_pkg::TASK_SHIFT] == '0)
        begin
            mig     = (span >= lbts_pkg::MIN_SPAN);
            mig_cnt = mig ? CNT_W'(1) : '0;
        end
        else
        begin
            mig     = 1'b1;
            mig_cnt = CNT_W'(gap >> lbts_pkg::TASK_SHIFT);
        end
    end

    // Result register, free when empty or being taken.
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = cmd.decide | cmd.zero_resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mig_reg <= cmd.decide & mig;
            out_tgt_reg <= (cmd.decide & mig) ? IN_W'(best_reg) : '0;
            out_cnt_reg <= cmd.decide ? mig_cnt : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_mig_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_reg, out_tgt_reg};

    // Status back to the controller.
    always_comb
    begin
        sts           = '0;
        sts.is_query  = query_reg;
        sts.me_ok     = (CMP_W'(me_reg) < CMP_W'(NUM_CPUS));
        sts.scan_last = (idx_reg == LAST_IDX);
        sts.div_busy  = div_busy;
        sts.out_free  = out_free;
    end

    `LBTS_ASSERT(a_no_write_during_scan, !(cmd.upd_wr && acc_pend_reg), "table write during scan")
    `LBTS_ASSERT(a_result_into_free_reg, out_load |-> out_free, "result overwrote a pending result")
    `LBTS_ASSERT(a_migrate_has_tasks, (out_valid_reg && out_mig_reg) |-> (out_cnt_reg != '0), "migration with zero tasks")
    `LBTS_ASSERT(a_div_before_decide, cmd.decide |-> (!div_busy && $past(!cmd.div_start)), "decision before average ready")

endmodule

[tb/sv/lbts_balance_tracker_pkg.sv]
// Tracker that mirrors the load table and queues the expected balance decisions.
package lbts_balance_tracker_pkg;

    import lbts_pkg::*;

    localparam int NCPU = DEF_NUM_CPUS;

    // Load units that stand for one ready task.
    localparam int unsigned TASK_LOAD = 128;
    // The asker must carry at least 1.25 times the lightest load to shed tasks.
    localparam int unsigned RATIO_NUM = 125;
    localparam int unsigned RATIO_DEN = 100;
    localparam int unsigned MAX_TASKS = 255;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } balance_cmd_e;

    typedef struct packed {
        logic                migrate;
        logic [2:0]          target;
        logic [CNT_W-1:0]    tasks;
    } move_t;

    class balance_tracker;

        logic [LOAD_W-1:0] cpu_load [NCPU];
        move_t             pending_moves [$];
        int                failures;

        function new();
            foreach (cpu_load[i])
                cpu_load[i] = '0;
            failures = 0;
        endfunction

        // Work out the decision that a query from one processor should produce.
        function move_t decide_move(logic [2:0] asker);
            move_t       mv;
            int unsigned own;
            int unsigned lowest;
            int unsigned total;
            int unsigned ave;
            int unsigned gap;
            logic [2:0]  best;
            bit          found;
            mv     = '0;
            best   = '0;
            found  = 1'b0;
            total  = 0;
            if (int'(asker) >= NCPU)
                return mv;
            own    = cpu_load[asker];
            lowest = own;
            // Later processors win ties, since the compare is less-or-equal.
            for (int i = 0; i < NCPU; i++) begin
                total += cpu_load[i];
                if (i != int'(asker) && cpu_load[i] <= lowest) begin
                    lowest = cpu_load[i];
                    best   = 3'(i);
                    found  = 1'b1;
                end
            end
            if (!found || own <= lowest)
                return mv;
            ave = total / NCPU;
            if (own <= ave || RATIO_DEN * own < RATIO_NUM * lowest)
                return mv;
            gap = ((ave - lowest) < (own - ave)) ? (ave - lowest) : (own - ave);
            if (gap < TASK_LOAD) begin
                // A small gap still moves one task when the spread is wide enough.
                if ((own - lowest) >= int'(MIN_SPAN)) begin
                    mv.migrate = 1'b1;
                    mv.target  = best;
                    mv.tasks   = 8'd1;
                end
                return mv;
            end
            gap = gap / TASK_LOAD;
            if (gap > MAX_TASKS)
                gap = MAX_TASKS;
            mv.migrate = 1'b1;
            mv.target  = best;
            mv.tasks   = CNT_W'(gap);
            return mv;
        endfunction

        // Apply an accepted input item to the mirrored state.
        function void note_item(logic cmd, logic [2:0] cpu, logic [CNT_W-1:0] cnt);
            int unsigned blended;
            if (cmd == CMD_UPDATE) begin
                if (int'(cpu) < NCPU) begin
                    blended       = cpu_load[cpu] + cnt * TASK_LOAD;
                    cpu_load[cpu] = LOAD_W'(blended / 2);
                end
            end
            else begin
                pending_moves.push_back(decide_move(cpu));
            end
        endfunction

        // Compare an accepted result item with the oldest expected decision.
        function void check_move(logic migrate, logic [2:0] target, logic [CNT_W-1:0] tasks);
            move_t exp_mv;
            if (pending_moves.size() == 0) begin
                $error("result item with no query waiting: migrate=%0d target=%0d tasks=%0d",
                       migrate, target, tasks);
                failures++;
                return;
            end
            exp_mv = pending_moves.pop_front();
            if (migrate !== exp_mv.migrate) begin
                $error("migrate: expected %0d, got %0d", exp_mv.migrate, migrate);
                failures++;
            end
            if (target !== exp_mv.target) begin
                $error("target_index: expected %0d, got %0d", exp_mv.target, target);
                failures++;
            end
            if (tasks !== exp_mv.tasks) begin
                $error("task_count: expected %0d, got %0d", exp_mv.tasks, tasks);
                failures++;
            end
        endfunction

        function int waiting();
            return pending_moves.size();
        endfunction

    endclass

endpackage

[tb/sv/tb_top.sv]
// Top of the load balance target selector testbench: clock, reset, drivers and checks.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lbts_pkg::*;
    import lbts_balance_tracker_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 670;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  rx_hold_left = 0;
    int                  cycle_count = 0;

    balance_tracker      tracker;

    load_balance_target_select #(
        .NUM_CPUS (NCPU)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial
    begin
        forever begin
            @(posedge clk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check every result item taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_move(m_tuser, m_tdata[2:0], m_tdata[10:3]);
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(logic cmd, logic [2:0] cpu, logic [CNT_W-1:0] cnt);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(TDATA_W - CNT_W - 3){1'b0}}, cnt, cpu};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_item(cmd, cpu, cnt);
    endtask

    // Stop offering and wait until every query has been answered.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.waiting() != 0)
            @(posedge clk);
    endtask

    // Random traffic around one heavily loaded processor, with some plain noise.
    task automatic send_random(int n_items);
        logic [2:0]       hot;
        logic [2:0]       cpu;
        logic [CNT_W-1:0] cnt;
        logic             cmd;
        hot = 3'($urandom_range(NCPU - 1));
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                hot = 3'($urandom_range(NCPU - 1));
            cmd = ($urandom_range(99) < 30) ? CMD_QUERY : CMD_UPDATE;
            cpu = 3'($urandom_range(NCPU - 1));
            cnt = 8'($urandom_range(255));
            if ($urandom_range(99) < 75) begin
                if (cmd == CMD_QUERY) begin
                    if ($urandom_range(99) < 70)
                        cpu = hot;
                end
                else if (cpu == hot) begin
                    cnt = 8'($urandom_range(255, 150));
                end
                else begin
                    cnt = 8'($urandom_range(60));
                end
            end
            send_item(cmd, cpu, cnt);
        end
    endtask

    // Main sequence.
    initial
    begin
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, small and wide spreads, ties and extremes.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(CMD_QUERY, 3'd0, 8'd0);
        send_item(CMD_QUERY, 3'd7, 8'd255);
        send_item(CMD_UPDATE, 3'd0, 8'd2);
        send_item(CMD_QUERY, 3'd0, 8'd0);
        send_item(CMD_UPDATE, 3'd0, 8'd3);
        send_item(CMD_QUERY, 3'd0, 8'd0);
        send_item(CMD_QUERY, 3'd7, 8'd0);
        repeat (4) send_item(CMD_UPDATE, 3'd0, 8'd255);
        send_item(CMD_QUERY, 3'd0, 8'd0);
        send_item(CMD_UPDATE, 3'd3, 8'd255);
        send_item(CMD_UPDATE, 3'd5, 8'd255);
        send_item(CMD_UPDATE, 3'd1, 8'd1);
        send_item(CMD_UPDATE, 3'd2, 8'd1);
        send_item(CMD_QUERY, 3'd0, 8'd0);
        send_item(CMD_UPDATE, 3'd7, 8'd170);
        send_item(CMD_UPDATE, 3'd6, 8'd85);
        send_item(CMD_QUERY, 3'd6, 8'd0);
        send_item(CMD_QUERY, 3'd3, 8'd0);
        send_item(CMD_QUERY, 3'd5, 8'd0);
        send_item(CMD_QUERY, 3'd1, 8'd0);
        wait_drained();

        // Receiver idles more than the sender.
        tx_idle_pct = 27;
        rx_idle_pct = 62;
        send_random(PHASE_ITEMS);
        wait_drained();

        // Sender idles more than the receiver.
        tx_idle_pct = 62;
        rx_idle_pct = 27;
        send_random(PHASE_ITEMS);
        wait_drained();

        // No idling; first a long receiver hold-off while queries keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = 500;
        for (int i = 0; i < 30; i++)
            send_item(CMD_QUERY, 3'($urandom_range(NCPU - 1)), 8'($urandom_range(255)));
        send_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.waiting() == 0) begin
            $display("tb_top passed");
        end
        else begin
            if (tracker.waiting() != 0)
                $error("%0d expected results never arrived", tracker.waiting());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/lbts_pkg.sv
sv/lbts_div.sv
sv/lbts_ctrl.sv
sv/lbts_dp.sv
sv/load_balance_target_select.sv
tb/sv/lbts_balance_tracker_pkg.sv
tb/sv/tb_top.sv
